[rtl/core/ctsc_pkg.sv]
// Shared types, command codes and field helpers for the clock, countdown
// and stopwatch controller. No dependencies.
`default_nettype none

package ctsc_pkg;

    // Event kinds carried in s_tuser.
    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_DIR   = 3'd1;
    localparam logic [2:0] CMD_JOY   = 3'd2;
    localparam logic [2:0] CMD_TURN  = 3'd3;
    localparam logic [2:0] CMD_PRESS = 3'd4;

    // Joystick directions.
    localparam logic [1:0] DIR_LEFT  = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_DOWN  = 2'd2;
    localparam logic [1:0] DIR_UP    = 2'd3;

    // Feature codes.
    localparam logic [1:0] FEAT_DOWN = 2'd0;
    localparam logic [1:0] FEAT_DAY  = 2'd1;
    localparam logic [1:0] FEAT_LAP  = 2'd2;

    // Field tops and reset value of the tick period.
    localparam logic [5:0] TOP_MIN_SEC    = 6'd59;
    localparam logic [5:0] TOP_HOUR       = 6'd23;
    localparam logic [3:0] TOP_TENTH      = 4'd9;
    localparam logic [7:0] TICKS_DEFAULT  = 8'd6;

    localparam int OUT_W = 56;

    // Complete controller state.
    typedef struct packed {
        logic [1:0] feature_sel;
        logic       editing;
        logic       down_field;
        logic [1:0] day_field;
        logic       down_running;
        logic       lap_running;
        logic [7:0] tick_count;
        logic [5:0] down_min;
        logic [5:0] down_sec;
        logic [3:0] down_tenth;
        logic [4:0] day_hour;
        logic [5:0] day_min;
        logic [5:0] day_sec;
        logic [3:0] day_tenth;
        logic [5:0] lap_min;
        logic [5:0] lap_sec;
        logic [3:0] lap_tenth;
    } ctsc_state_t;

    // One encoder step on a field, wrapping between zero and top.
    function automatic logic [5:0] step_field(input logic [5:0] v, input logic [5:0] top,
                                              input logic down);
        logic [5:0] r;
        if (down) begin
            r = (v == 6'd0 || v > top) ? top : v - 6'd1;
        end else begin
            r = (v >= top) ? 6'd0 : v + 6'd1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/core/ctsc_update.sv]
// Next-state logic of the controller for one event.
// Depends on ctsc_pkg for the state type, codes and step_field.
`default_nettype none

module ctsc_update import ctsc_pkg::*; (
    input  ctsc_state_t state_i,
    input  logic [2:0]  cmd,
    input  logic [1:0]  direction,
    input  logic        turn_down,
    input  logic [7:0]  ticks_per_tenth,
    output ctsc_state_t state_o
);

    logic [7:0]  tick_inc;
    ctsc_state_t tenth_st;

    assign tick_inc = state_i.tick_count + 8'd1;

    // State after a tenth of a second passes.
    always_comb begin
        tenth_st = state_i;
        tenth_st.tick_count = 8'd0;

        // Time of day counts up and wraps at 24 hours.
        if (state_i.day_tenth >= TOP_TENTH) begin
            tenth_st.day_tenth = 4'd0;
            if (state_i.day_sec >= TOP_MIN_SEC) begin
                tenth_st.day_sec = 6'd0;
                if (state_i.day_min >= TOP_MIN_SEC) begin
                    tenth_st.day_min = 6'd0;
                    tenth_st.day_hour = (state_i.day_hour >= TOP_HOUR[4:0]) ? 5'd0
                                        : state_i.day_hour + 5'd1;
                end else begin
                    tenth_st.day_min = state_i.day_min + 6'd1;
                end
            end else begin
                tenth_st.day_sec = state_i.day_sec + 6'd1;
            end
        end else begin
            tenth_st.day_tenth = state_i.day_tenth + 4'd1;
        end

        // Countdown counts down and wraps from zero to the top.
        if (state_i.down_running) begin
            if (state_i.down_tenth == 4'd0) begin
                tenth_st.down_tenth = TOP_TENTH;
                if (state_i.down_sec == 6'd0) begin
                    tenth_st.down_sec = TOP_MIN_SEC;
                    tenth_st.down_min = (state_i.down_min == 6'd0) ? TOP_MIN_SEC
                                        : state_i.down_min - 6'd1;
                end else begin
                    tenth_st.down_sec = state_i.down_sec - 6'd1;
                end
            end else begin
                tenth_st.down_tenth = state_i.down_tenth - 4'd1;
            end
        end

        // Stopwatch counts up and wraps at 60 minutes.
        if (state_i.lap_running) begin
            if (state_i.lap_tenth >= TOP_TENTH) begin
                tenth_st.lap_tenth = 4'd0;
                if (state_i.lap_sec >= TOP_MIN_SEC) begin
                    tenth_st.lap_sec = 6'd0;
                    tenth_st.lap_min = (state_i.lap_min >= TOP_MIN_SEC) ? 6'd0
                                       : state_i.lap_min + 6'd1;
                end else begin
                    tenth_st.lap_sec = state_i.lap_sec + 6'd1;
                end
            end else begin
                tenth_st.lap_tenth = state_i.lap_tenth + 4'd1;
            end
        end
    end

    // Event decode.
    always_comb begin
        state_o = state_i;
        unique case (cmd)
            CMD_TICK: begin
                if (tick_inc >= ticks_per_tenth) begin
                    state_o = tenth_st;
                end else begin
                    state_o.tick_count = tick_inc;
                end
            end
            CMD_DIR: begin
                if (!state_i.editing) begin
                    if (state_i.feature_sel == FEAT_DOWN && direction == DIR_RIGHT) begin
                        state_o.feature_sel = FEAT_DAY;
                    end else if (state_i.feature_sel == FEAT_DOWN && direction == DIR_DOWN) begin
                        state_o.feature_sel = FEAT_LAP;
                    end else if (state_i.feature_sel == FEAT_DAY && direction == DIR_LEFT) begin
                        state_o.feature_sel = FEAT_DOWN;
                    end else if (state_i.feature_sel == FEAT_LAP && direction == DIR_UP) begin
                        state_o.feature_sel = FEAT_DOWN;
                    end
                end else if (direction == DIR_RIGHT) begin
                    if (state_i.feature_sel == FEAT_DOWN && !state_i.down_field) begin
                        state_o.down_field = 1'b1;
                    end else if (state_i.feature_sel == FEAT_DAY
                                 && state_i.day_field < 2'd2) begin
                        state_o.day_field = state_i.day_field + 2'd1;
                    end
                end else if (direction == DIR_LEFT) begin
                    if (state_i.feature_sel == FEAT_DOWN && state_i.down_field) begin
                        state_o.down_field = 1'b0;
                    end else if (state_i.feature_sel == FEAT_DAY
                                 && state_i.day_field > 2'd0) begin
                        state_o.day_field = state_i.day_field - 2'd1;
                    end
                end
            end
            CMD_JOY: begin
                state_o.editing = ~state_i.editing;
            end
            CMD_TURN: begin
                if (state_i.editing) begin
                    if (state_i.feature_sel == FEAT_DOWN) begin
                        if (!state_i.down_field) begin
                            state_o.down_min = step_field(state_i.down_min, TOP_MIN_SEC,
                                                          turn_down);
                        end else begin
                            state_o.down_sec = step_field(state_i.down_sec, TOP_MIN_SEC,
                                                          turn_down);
                        end
                    end else if (state_i.feature_sel == FEAT_DAY) begin
                        if (state_i.day_field == 2'd0) begin
                            state_o.day_hour = 5'(step_field({1'b0, state_i.day_hour},
                                                             TOP_HOUR, turn_down));
                        end else if (state_i.day_field == 2'd1) begin
                            state_o.day_min = step_field(state_i.day_min, TOP_MIN_SEC,
                                                         turn_down);
                        end else begin
                            state_o.day_sec = step_field(state_i.day_sec, TOP_MIN_SEC,
                                                         turn_down);
                        end
                    end
                end
            end
            CMD_PRESS: begin
                if (!state_i.editing) begin
                    if (state_i.feature_sel == FEAT_DOWN) begin
                        state_o.down_running = ~state_i.down_running;
                    end else if (state_i.feature_sel == FEAT_LAP) begin
                        state_o.lap_running = ~state_i.lap_running;
                    end
                end else if (state_i.feature_sel == FEAT_DOWN) begin
                    state_o.down_min = 6'd0;
                    state_o.down_sec = 6'd0;
                    state_o.down_tenth = 4'd0;
                end else if (state_i.feature_sel == FEAT_DAY) begin
                    state_o.day_hour = 5'd0;
                    state_o.day_min = 6'd0;
                    state_o.day_sec = 6'd0;
                    state_o.day_tenth = 4'd0;
                end else if (state_i.feature_sel == FEAT_LAP) begin
                    state_o.lap_min = 6'd0;
                    state_o.lap_sec = 6'd0;
                    state_o.lap_tenth = 4'd0;
                end
            end
            default: begin
                // Unknown events leave the state as it is.
                state_o = state_i;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/clock_timer_stopwatch_controller.sv]
// Top level of the clock, countdown and stopwatch controller.
// Depends on ctsc_pkg and ctsc_update.
//
// Usage: each request on the s_ channel is one event (tick, joystick
// direction, joystick press, encoder step or encoder press) selected by
// s_tuser. Each event yields exactly one request on the m_ channel carrying
// the mode, selected field, run flags and all three times after the event.
// A request passes through the input register and the result register on its
// way to m_. Throughput: one event per cycle while m_tready is high, set by
// the combinational state update between the input and result registers.
// A stalled m_ side holds its result; one further event is accepted into the
// input register, after which s_tready stays low until m_tready returns.
// Reset (aresetn low, synchronous) zeroes all times and modes, clears both
// pipeline valid flags and loads ticks_per_tenth with 6. cfg_we writes
// ticks_per_tenth; it should only be written while the block is idle.
`default_nettype none

module clock_timer_stopwatch_controller import ctsc_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // Configuration: ticks_per_tenth.
    input  wire logic              cfg_we,
    input  wire logic [7:0]        cfg_wdata,
    // Event input.
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,   // [1:0] direction, [2] turn_down
    input  wire logic [2:0]        s_tuser,   // [2:0] cmd
    // Result output.
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // [2:0] ui_mode, [4:3] edit_field, [6:5] run_flags, [12:7] down_minutes,
    // [18:13] down_seconds, [22:19] down_tenths, [27:23] day_hours,
    // [33:28] day_minutes, [39:34] day_seconds, [45:40] lap_minutes,
    // [51:46] lap_seconds, [55:52] lap_tenths
    output logic [OUT_W-1:0]       m_tdata
);

    logic             in_valid_reg;
    logic [2:0]       cmd_reg;
    logic [1:0]       dir_reg;
    logic             turn_reg;
    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic [OUT_W-1:0] out_data_next;
    logic [7:0]       tpt_reg;
    ctsc_state_t      state_reg;
    ctsc_state_t      state_next;
    logic             advance;
    logic [1:0]       field_next;

    // An event moves from the input register into the result register.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    ctsc_update u_update (
        .state_i         (state_reg),
        .cmd             (cmd_reg),
        .direction       (dir_reg),
        .turn_down       (turn_reg),
        .ticks_per_tenth (tpt_reg),
        .state_o         (state_next)
    );

    // Field shown for the current feature.
    always_comb begin
        if (state_next.feature_sel == FEAT_DOWN) begin
            field_next = {1'b0, state_next.down_field} + 2'd1;
        end else if (state_next.feature_sel == FEAT_DAY) begin
            field_next = state_next.day_field;
        end else begin
            field_next = 2'd1;
        end
    end

    // Result packing, highest field first.
    assign out_data_next = {state_next.lap_tenth, state_next.lap_sec, state_next.lap_min,
                            state_next.day_sec, state_next.day_min, state_next.day_hour,
                            state_next.down_tenth, state_next.down_sec,
                            state_next.down_min,
                            state_next.lap_running, state_next.down_running,
                            field_next,
                            state_next.feature_sel, state_next.editing};

    // Control and state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
            tpt_reg       <= TICKS_DEFAULT;
        end else begin
            if (cfg_we) begin
                tpt_reg <= cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cmd_reg  <= s_tuser;
            dir_reg  <= s_tdata[1:0];
            turn_reg <= s_tdata[2];
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire

[sim/tb_clock_timer_stopwatch_controller.sv]
// Self-checking testbench for clock_timer_stopwatch_controller: drives event
// requests, predicts every status request and compares them field by field.
// Depends on ctsc_pkg and the controller RTL.
`default_nettype none

module tb_clock_timer_stopwatch_controller;
    import ctsc_pkg::*;

    // Event codes that the block must treat as no-ops.
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
    localparam int RANDOM_PHASES     = 6;
    localparam int EVENTS_PER_PHASE  = 250;
    localparam int ROLLOVER_TICKS    = 120;
    localparam int DRAIN_LIMIT       = 5000;

    // Status word as it appears on m_tdata, highest field first.
    typedef struct packed {
        logic [3:0] lap_tenths;
        logic [5:0] lap_seconds;
        logic [5:0] lap_minutes;
        logic [5:0] day_seconds;
        logic [5:0] day_minutes;
        logic [4:0] day_hours;
        logic [3:0] down_tenths;
        logic [5:0] down_seconds;
        logic [5:0] down_minutes;
        logic [1:0] run_flags;
        logic [1:0] edit_field;
        logic [2:0] ui_mode;
    } status_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_we = 1'b0;
    logic [7:0]        cfg_wdata = 8'd0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata = 8'd0;   // [1:0] direction, [2] turn_down
    logic [2:0]        s_tuser = 3'd0;   // [2:0] cmd
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    // [2:0] ui_mode, [4:3] edit_field, [6:5] run_flags, [12:7] down_minutes,
    // [18:13] down_seconds, [22:19] down_tenths, [27:23] day_hours,
    // [33:28] day_minutes, [39:34] day_seconds, [45:40] lap_minutes,
    // [51:46] lap_seconds, [55:52] lap_tenths
    logic [OUT_W-1:0]  m_tdata;

    clock_timer_stopwatch_controller DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Predicted controller state.
    logic [7:0] period;
    logic [1:0] sel_feature;
    logic       edit_mode;
    logic       cd_field;
    logic [1:0] tod_field;
    logic       cd_run;
    logic       sw_run;
    logic [7:0] tick_cnt;
    logic [5:0] cd_min, cd_sec;
    logic [3:0] cd_tenth;
    logic [4:0] tod_hour;
    logic [5:0] tod_min, tod_sec;
    logic [3:0] tod_tenth;
    logic [5:0] sw_min, sw_sec;
    logic [3:0] sw_tenth;

    status_t status_q[$];
    int      mismatches = 0;
    int      results_seen = 0;
    int      stall_left = 0;
    bit      no_gaps = 1'b0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [5:0] wrap_step(logic [5:0] v, logic [5:0] top, logic dec);
        if (dec) return (v == 6'd0 || v > top) ? top : v - 6'd1;
        return (v >= top) ? 6'd0 : v + 6'd1;
    endfunction

    // One tenth of a second: clock always, countdown and stopwatch if running.
    function automatic void pass_tenth();
        tod_tenth = tod_tenth + 4'd1;
        if (tod_tenth > TOP_TENTH) begin
            tod_tenth = 4'd0;
            tod_sec = tod_sec + 6'd1;
            if (tod_sec > TOP_MIN_SEC) begin
                tod_sec = 6'd0;
                tod_min = tod_min + 6'd1;
                if (tod_min > TOP_MIN_SEC) begin
                    tod_min = 6'd0;
                    tod_hour = tod_hour + 5'd1;
                    if (tod_hour > TOP_HOUR) tod_hour = 5'd0;
                end
            end
        end
        if (cd_run) begin
            if (cd_tenth == 4'd0) begin
                cd_tenth = TOP_TENTH;
                if (cd_sec == 6'd0) begin
                    cd_sec = TOP_MIN_SEC;
                    cd_min = (cd_min == 6'd0) ? TOP_MIN_SEC : cd_min - 6'd1;
                end else begin
                    cd_sec = cd_sec - 6'd1;
                end
            end else begin
                cd_tenth = cd_tenth - 4'd1;
            end
        end
        if (sw_run) begin
            sw_tenth = sw_tenth + 4'd1;
            if (sw_tenth > TOP_TENTH) begin
                sw_tenth = 4'd0;
                sw_sec = sw_sec + 6'd1;
                if (sw_sec > TOP_MIN_SEC) begin
                    sw_sec = 6'd0;
                    sw_min = sw_min + 6'd1;
                    if (sw_min > TOP_MIN_SEC) sw_min = 6'd0;
                end
            end
        end
    endfunction

    // Applies one accepted event to the predicted state.
    function automatic void apply_event(logic [2:0] cmd, logic [1:0] dir, logic dec);
        logic [5:0] hour6;
        case (cmd)
            CMD_TICK: begin
                tick_cnt = tick_cnt + 8'd1;
                if (tick_cnt >= period) begin
                    tick_cnt = 8'd0;
                    pass_tenth();
                end
            end
            CMD_DIR: begin
                if (!edit_mode) begin
                    if (sel_feature == FEAT_DOWN && dir == DIR_RIGHT) sel_feature = FEAT_DAY;
                    else if (sel_feature == FEAT_DOWN && dir == DIR_DOWN) sel_feature = FEAT_LAP;
                    else if (sel_feature == FEAT_DAY && dir == DIR_LEFT) sel_feature = FEAT_DOWN;
                    else if (sel_feature == FEAT_LAP && dir == DIR_UP) sel_feature = FEAT_DOWN;
                end else if (dir == DIR_RIGHT) begin
                    if (sel_feature == FEAT_DOWN && !cd_field) cd_field = 1'b1;
                    else if (sel_feature == FEAT_DAY && tod_field < 2'd2)
                        tod_field = tod_field + 2'd1;
                end else if (dir == DIR_LEFT) begin
                    if (sel_feature == FEAT_DOWN && cd_field) cd_field = 1'b0;
                    else if (sel_feature == FEAT_DAY && tod_field > 2'd0)
                        tod_field = tod_field - 2'd1;
                end
            end
            CMD_JOY: edit_mode = ~edit_mode;
            CMD_TURN: begin
                if (edit_mode && sel_feature == FEAT_DOWN) begin
                    if (!cd_field) cd_min = wrap_step(cd_min, TOP_MIN_SEC, dec);
                    else cd_sec = wrap_step(cd_sec, TOP_MIN_SEC, dec);
                end else if (edit_mode && sel_feature == FEAT_DAY) begin
                    if (tod_field == 2'd0) begin
                        hour6 = wrap_step({1'b0, tod_hour}, TOP_HOUR, dec);
                        tod_hour = hour6[4:0];
                    end else if (tod_field == 2'd1) begin
                        tod_min = wrap_step(tod_min, TOP_MIN_SEC, dec);
                    end else begin
                        tod_sec = wrap_step(tod_sec, TOP_MIN_SEC, dec);
                    end
                end
            end
            CMD_PRESS: begin
                if (!edit_mode) begin
                    if (sel_feature == FEAT_DOWN) cd_run = ~cd_run;
                    else if (sel_feature == FEAT_LAP) sw_run = ~sw_run;
                end else if (sel_feature == FEAT_DOWN) begin
                    cd_min = 6'd0; cd_sec = 6'd0; cd_tenth = 4'd0;
                end else if (sel_feature == FEAT_DAY) begin
                    tod_hour = 5'd0; tod_min = 6'd0; tod_sec = 6'd0; tod_tenth = 4'd0;
                end else if (sel_feature == FEAT_LAP) begin
                    sw_min = 6'd0; sw_sec = 6'd0; sw_tenth = 4'd0;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic status_t current_status();
        status_t s;
        s.ui_mode = {sel_feature, edit_mode};
        if (sel_feature == FEAT_DOWN) s.edit_field = {1'b0, cd_field} + 2'd1;
        else if (sel_feature == FEAT_DAY) s.edit_field = tod_field;
        else s.edit_field = 2'd1;
        s.run_flags    = {sw_run, cd_run};
        s.down_minutes = cd_min;
        s.down_seconds = cd_sec;
        s.down_tenths  = cd_tenth;
        s.day_hours    = tod_hour;
        s.day_minutes  = tod_min;
        s.day_seconds  = tod_sec;
        s.lap_minutes  = sw_min;
        s.lap_seconds  = sw_sec;
        s.lap_tenths   = sw_tenth;
        return s;
    endfunction

    function automatic bit fields_match(status_t a, status_t b);
        return a.ui_mode === b.ui_mode && a.edit_field === b.edit_field &&
               a.run_flags === b.run_flags && a.down_minutes === b.down_minutes &&
               a.down_seconds === b.down_seconds && a.down_tenths === b.down_tenths &&
               a.day_hours === b.day_hours && a.day_minutes === b.day_minutes &&
               a.day_seconds === b.day_seconds && a.lap_minutes === b.lap_minutes &&
               a.lap_seconds === b.lap_seconds && a.lap_tenths === b.lap_tenths;
    endfunction

    function automatic string fmt_status(status_t s);
        return $sformatf({"mode %0d field %0d run %0d cd %0d:%0d.%0d ",
                          "tod %0d:%0d:%0d sw %0d:%0d.%0d"},
                         s.ui_mode, s.edit_field, s.run_flags, s.down_minutes,
                         s.down_seconds, s.down_tenths, s.day_hours, s.day_minutes,
                         s.day_seconds, s.lap_minutes, s.lap_seconds, s.lap_tenths);
    endfunction

    // Result side: check each status request, then pick the next stall.
    initial begin
        status_t got, want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got = status_t'(m_tdata);
                if (status_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected status request: %s", fmt_status(got));
                end else begin
                    want = status_q.pop_front();
                    if (!fields_match(want, got)) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch on status %0d", results_seen);
                            $display("  expected %s", fmt_status(want));
                            $display("  actual   %s", fmt_status(got));
                        end
                    end
                end
                results_seen++;
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // Sends one event request and records the status it should produce.
    task automatic send_event(input logic [2:0] cmd, input logic [1:0] dir, input logic dec);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {5'b0, dec, dir};
        do @(posedge aclk); while (!s_tready);
        apply_event(cmd, dir, dec);
        status_q.push_back(current_status());
    endtask

    // Stops sending and waits for all outstanding status requests.
    task automatic drain_results();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (status_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_period(input logic [7:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        period = value;
    endtask

    // Spare event codes leave everything as it is.
    task automatic test_spare_codes();
        for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++)
            send_event(3'(c), 2'(c), c[0]);
    endtask

    // Countdown: start, wrap below zero, stop, edit seconds with wrap, zero it.
    task automatic test_countdown();
        set_period(8'd0);
        send_event(CMD_PRESS, DIR_LEFT, 1'b0);
        send_event(CMD_TICK, DIR_LEFT, 1'b0);
        send_event(CMD_PRESS, DIR_LEFT, 1'b0);
        send_event(CMD_JOY, DIR_LEFT, 1'b0);
        send_event(CMD_DIR, DIR_RIGHT, 1'b0);
        send_event(CMD_TURN, DIR_LEFT, 1'b0);
        send_event(CMD_TURN, DIR_LEFT, 1'b1);
        send_event(CMD_PRESS, DIR_LEFT, 1'b0);
        send_event(CMD_JOY, DIR_LEFT, 1'b0);
    endtask

    // Clock: press does nothing, set 23:59:59 by stepping down, edge moves.
    task automatic test_clock_edit();
        send_event(CMD_DIR, DIR_RIGHT, 1'b0);
        send_event(CMD_PRESS, DIR_LEFT, 1'b0);
        send_event(CMD_JOY, DIR_LEFT, 1'b0);
        send_event(CMD_TURN, DIR_LEFT, 1'b1);
        send_event(CMD_DIR, DIR_RIGHT, 1'b0);
        send_event(CMD_TURN, DIR_LEFT, 1'b1);
        send_event(CMD_DIR, DIR_RIGHT, 1'b0);
        send_event(CMD_TURN, DIR_LEFT, 1'b1);
        send_event(CMD_DIR, DIR_RIGHT, 1'b0);
        send_event(CMD_DIR, DIR_UP, 1'b0);
        send_event(CMD_JOY, DIR_LEFT, 1'b0);
    endtask

    // Longest period, then a lower one below the running tick count.
    task automatic test_tick_period();
        set_period(8'd255);
        send_event(CMD_TICK, DIR_LEFT, 1'b0);
        send_event(CMD_TICK, DIR_LEFT, 1'b0);
        set_period(8'd1);
        send_event(CMD_TICK, DIR_LEFT, 1'b0);
    endtask

    // Stopwatch: start it, editing changes nothing, restart the countdown.
    task automatic test_stopwatch();
        send_event(CMD_DIR, DIR_LEFT, 1'b0);
        send_event(CMD_DIR, DIR_DOWN, 1'b0);
        send_event(CMD_PRESS, DIR_LEFT, 1'b0);
        send_event(CMD_JOY, DIR_LEFT, 1'b0);
        send_event(CMD_TURN, DIR_LEFT, 1'b0);
        send_event(CMD_JOY, DIR_LEFT, 1'b0);
        send_event(CMD_DIR, DIR_UP, 1'b0);
        send_event(CMD_PRESS, DIR_LEFT, 1'b0);
    endtask

    // Twelve seconds of tenths back to back: the clock, set just before
    // midnight, wraps to zero while the countdown and stopwatch keep running.
    task automatic test_rollover();
        set_period(TICKS_DEFAULT);
        set_period(8'd1);
        no_gaps = 1'b1;
        repeat (ROLLOVER_TICKS) send_event(CMD_TICK, DIR_LEFT, 1'b0);
        no_gaps = 1'b0;
    endtask

    // Random events over several tick periods, one phase without gaps.
    task automatic test_random_events();
        int r;
        logic [2:0] cmd;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: set_period(8'($urandom_range(2, 12)));
                1: set_period(8'd255);
                2: set_period(8'd0);
                3: set_period(TICKS_DEFAULT);
                4: set_period(8'($urandom_range(1, 255)));
                default: set_period(8'd1);
            endcase
            no_gaps = (p == 3);
            repeat (EVENTS_PER_PHASE) begin
                r = $urandom_range(0, 99);
                if (r < 40) cmd = CMD_TICK;
                else if (r < 55) cmd = CMD_DIR;
                else if (r < 65) cmd = CMD_JOY;
                else if (r < 82) cmd = CMD_TURN;
                else if (r < 95) cmd = CMD_PRESS;
                else cmd = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
                send_event(cmd, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
            end
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        period = TICKS_DEFAULT;
        sel_feature = FEAT_DOWN; edit_mode = 1'b0; cd_field = 1'b0; tod_field = 2'd0;
        cd_run = 1'b0; sw_run = 1'b0; tick_cnt = 8'd0;
        cd_min = 6'd0; cd_sec = 6'd0; cd_tenth = 4'd0;
        tod_hour = 5'd0; tod_min = 6'd0; tod_sec = 6'd0; tod_tenth = 4'd0;
        sw_min = 6'd0; sw_sec = 6'd0; sw_tenth = 4'd0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_spare_codes();
        test_countdown();
        test_clock_edit();
        test_tick_period();
        test_stopwatch();
        test_rollover();
        test_random_events();

        drain_results();
        mismatches += status_q.size();
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
